>>> rtl/core/mst_pkg.sv
// shared types and constants of the matrix stack
`default_nettype none
package mst_pkg;
	localparam int StackDepthDef = 128;
	localparam int FracBitsDef   = 16;

	typedef enum logic [2:0] {
		FUNC_CLEAR   = 3'd0,
		FUNC_PUSHC   = 3'd1,
		FUNC_PUSHM   = 3'd2,
		FUNC_POP     = 3'd3,
		FUNC_PREMUL  = 3'd4,
		FUNC_SET     = 3'd5,
		FUNC_GET     = 3'd6,
		FUNC_NONE    = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	typedef logic signed [31:0] elem_t;
	typedef elem_t row_t [4];

	typedef struct packed {
		logic [2:0] func;
		logic [1:0] row;
		logic signed [31:0] e0;
		logic signed [31:0] e1;
		logic signed [31:0] e2;
		logic signed [31:0] e3;
	} in_item_t;

	typedef struct packed {
		logic [1:0] out_row;
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic signed [31:0] r3;
		logic [1:0] status;
		logic [6:0] level;
		logic last;
	} out_item_t;

	// result of one element: value plus saturation flag
	typedef struct packed {
		logic signed [31:0] val;
		logic sat;
	} dot_res_t;
endpackage
`default_nettype wire

>>> rtl/core/mst_if.sv
// valid/ready channel carrying one item
`default_nettype none
interface mst_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mst_dot.sv
// one lane: four products registered, then summed, shifted and saturated combinationally
`default_nettype none
module mst_dot import mst_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDef
) (
	input  wire logic clk,
	input  wire logic signed [31:0] a0,
	input  wire logic signed [31:0] a1,
	input  wire logic signed [31:0] a2,
	input  wire logic signed [31:0] a3,
	input  wire logic signed [31:0] b0,
	input  wire logic signed [31:0] b1,
	input  wire logic signed [31:0] b2,
	input  wire logic signed [31:0] b3,
	output dot_res_t res
);
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [65:0] sum;
	logic signed [65:0] sh;

	always_ff @(posedge clk) begin
		p0_s1 <= 64'(a0 * b0);
		p1_s1 <= 64'(a1 * b1);
		p2_s1 <= 64'(a2 * b2);
		p3_s1 <= 64'(a3 * b3);
	end

	always_comb begin
		sum = 66'(p0_s1) + 66'(p1_s1) + 66'(p2_s1) + 66'(p3_s1);
		sh = sum >>> FRAC_BITS;
		if (sh > 66'sh7FFFFFFF) begin
			res.val = 32'sh7FFFFFFF;
			res.sat = 1'b1;
		end else if (sh < -66'sh80000000) begin
			res.val = 32'sh80000000;
			res.sat = 1'b1;
		end else begin
			res.val = sh[31:0];
			res.sat = 1'b0;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/mst_store.sv
// saved matrix memory: one row of four elements per entry, registered read
`default_nettype none
module mst_store import mst_pkg::*; #(
	parameter int STACK_DEPTH = StackDepthDef,
	localparam int AW = $clog2((STACK_DEPTH - 1) * 4)
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [127:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [127:0] rdata
);
	logic [127:0] mem [(STACK_DEPTH - 1) * 4];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/matrix_stack_4x4_unit.sv
// top level of the 4x4 transform matrix stack
// Items are taken one at a time: the input is ready only while the block is idle and the
// output register is empty or being emptied. Operand rows 0..2 of push matrix, premultiply
// and set are stored in the operand registers as they are accepted. Push copy, push matrix
// and pop move the 4 rows of the top matrix through the saved-matrix memory one row a
// cycle; premultiply runs four lanes over one result row per cycle; get streams 4 result
// transactions, one a cycle while the output is not stalled. A result waiting in the output
// register keeps the next item from being taken.
`default_nettype none
module matrix_stack_4x4_unit import mst_pkg::*; #(
	parameter int STACK_DEPTH = StackDepthDef,
	parameter int FRAC_BITS = FracBitsDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mst_if.sink   in_ch,
	mst_if.source out_ch
);
	localparam int AW = $clog2((STACK_DEPTH - 1) * 4);
	localparam int LW = $clog2(STACK_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MOVE = 6'b000010,
		S_MUL  = 6'b000100,
		S_RES  = 6'b001000,
		S_GET  = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] top_q [16];
	logic [31:0] opr_q [12];
	logic [31:0] newm_q [16];
	logic [LW-1:0] lvl_q;
	logic [2:0] cnt_q;
	func_t func_q;
	logic [1:0] status_q;
	logic sat_q;
	logic ov_q;
	out_item_t out_q;
	logic [1:0] getrow_q;

	in_item_t in_d;
	assign in_d = in_ch.data;
	func_t f;
	assign f = func_t'(in_d.func);

	logic out_free;
	assign out_free = !out_ch.valid || out_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.data = out_q;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;

	// memory
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [127:0] wdata, rdata;
	mst_store #(.STACK_DEPTH(STACK_DEPTH)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// multiply lanes: row cnt of operand times column j of top
	logic [1:0] mrow;
	assign mrow = cnt_q[1:0];
	dot_res_t dres [4];
	for (genvar j = 0; j < 4; j++) begin : g_lane
		mst_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
			.clk,
			.a0(newm_q[{mrow, 2'd0}]), .a1(newm_q[{mrow, 2'd1}]),
			.a2(newm_q[{mrow, 2'd2}]), .a3(newm_q[{mrow, 2'd3}]),
			.b0(top_q[j]), .b1(top_q[4 + j]), .b2(top_q[8 + j]), .b3(top_q[12 + j]),
			.res(dres[j])
		);
	end

	logic [1:0] mrow_s1;
	logic mv_s1;
	logic [31:0] prod_q [16];

	logic push, fire;
	logic [AW-1:0] base;
	assign push = (func_q == FUNC_PUSHC) || (func_q == FUNC_PUSHM);
	assign base = AW'({lvl_q, 2'b00});
	always_comb begin
		we = (state_q == S_MOVE) && push && (cnt_q < 3'd4);
		waddr = base + AW'(cnt_q[1:0]);
		wdata = {top_q[{cnt_q[1:0], 2'd3}], top_q[{cnt_q[1:0], 2'd2}],
			top_q[{cnt_q[1:0], 2'd1}], top_q[{cnt_q[1:0], 2'd0}]};
		raddr = base - AW'(4) + AW'(cnt_q[1:0]);
	end
	assign fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < 16; i++) begin
				top_q[i] <= (i % 5 == 0) ? 32'(1) << FRAC_BITS : 32'd0;
			end
			lvl_q <= '0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			func_q <= FUNC_NONE;
			status_q <= ST_OK;
			sat_q <= 1'b0;
			getrow_q <= '0;
			mv_s1 <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				ov_q <= 1'b0;
			end
			mv_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						func_q <= f;
						status_q <= ST_OK;
						cnt_q <= '0;
						sat_q <= 1'b0;
						case (f)
							FUNC_CLEAR: begin
								for (int i = 0; i < 16; i++) begin
									top_q[i] <= (i % 5 == 0) ? 32'(1) << FRAC_BITS : 32'd0;
								end
								lvl_q <= '0;
								state_q <= S_RES;
							end
							FUNC_PUSHC, FUNC_PUSHM, FUNC_SET, FUNC_PREMUL: begin
								if (f != FUNC_PUSHC && in_d.row != 2'd3) begin
									opr_q[{in_d.row, 2'd0}] <= in_d.e0;
									opr_q[{in_d.row, 2'd1}] <= in_d.e1;
									opr_q[{in_d.row, 2'd2}] <= in_d.e2;
									opr_q[{in_d.row, 2'd3}] <= in_d.e3;
								end else begin
									for (int i = 0; i < 12; i++) newm_q[i] <= opr_q[i];
									newm_q[12] <= in_d.e0;
									newm_q[13] <= in_d.e1;
									newm_q[14] <= in_d.e2;
									newm_q[15] <= in_d.e3;
									if (f == FUNC_SET) begin
										state_q <= S_MOVE;
										cnt_q <= 3'd4;
									end else if (f == FUNC_PREMUL) begin
										state_q <= S_MUL;
									end else if (32'(lvl_q) >= STACK_DEPTH - 1) begin
										status_q <= ST_OVER;
										state_q <= S_RES;
									end else begin
										state_q <= S_MOVE;
									end
								end
							end
							FUNC_POP: begin
								if (lvl_q == '0) begin
									status_q <= ST_UNDER;
									state_q <= S_RES;
								end else begin
									state_q <= S_MOVE;
								end
							end
							FUNC_GET: begin
								getrow_q <= '0;
								state_q <= S_GET;
							end
							default: ;
						endcase
					end
				end
				S_MOVE: begin
					// push writes rows 0..3 then finishes; pop reads rows, data arriving in the cycle after the read
					cnt_q <= cnt_q + 3'd1;
					if (func_q == FUNC_POP && cnt_q != 3'd0) begin
						for (int c = 0; c < 4; c++) begin
							top_q[{cnt_q[1:0] - 2'd1, 2'(c)}] <= rdata[c*32 +: 32];
						end
					end
					if (func_q == FUNC_POP && cnt_q == 3'd4) begin
						lvl_q <= lvl_q - LW'(1);
						state_q <= S_RES;
					end else if (func_q != FUNC_POP && cnt_q == 3'd4) begin
						if (func_q != FUNC_PUSHC) begin
							for (int i = 0; i < 16; i++) top_q[i] <= newm_q[i];
						end
						if (push) lvl_q <= lvl_q + LW'(1);
						state_q <= S_RES;
					end
				end
				S_MUL: begin
					if (cnt_q < 3'd4) begin
						cnt_q <= cnt_q + 3'd1;
						mv_s1 <= 1'b1;
					end
					if (mv_s1) begin
						for (int j = 0; j < 4; j++) begin
							prod_q[{mrow_s1, 2'(j)}] <= dres[j].val;
						end
						if (dres[0].sat || dres[1].sat || dres[2].sat || dres[3].sat) begin
							sat_q <= 1'b1;
						end
						if (mrow_s1 == 2'd3) begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					for (int i = 0; i < 16; i++) top_q[i] <= prod_q[i];
					if (sat_q) status_q <= ST_SAT;
					state_q <= S_RES;
				end
				S_RES: begin
					if (out_free) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_GET: begin
					if (out_free) begin
						ov_q <= 1'b1;
						getrow_q <= getrow_q + 2'd1;
						if (getrow_q == 2'd3) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mrow_s1 <= mrow;
		if (state_q == S_RES && out_free) begin
			out_q.out_row <= '0;
			out_q.r0 <= '0;
			out_q.r1 <= '0;
			out_q.r2 <= '0;
			out_q.r3 <= '0;
			out_q.status <= status_q;
			out_q.level <= 7'(lvl_q);
			out_q.last <= 1'b1;
		end else if (state_q == S_GET && out_free) begin
			out_q.out_row <= getrow_q;
			out_q.r0 <= top_q[{getrow_q, 2'd0}];
			out_q.r1 <= top_q[{getrow_q, 2'd1}];
			out_q.r2 <= top_q[{getrow_q, 2'd2}];
			out_q.r3 <= top_q[{getrow_q, 2'd3}];
			out_q.status <= ST_OK;
			out_q.level <= 7'(lvl_q);
			out_q.last <= (getrow_q == 2'd3);
		end
	end
endmodule
`default_nettype wire
